// ===== hdl/fmdr_pkg.sv =====
package fmdr_pkg;

    localparam int NUM_WIDTH_DEF = 16;
    localparam int IN_W   = 16;
    localparam int WORD_W = 32;
    localparam int ERR_W  = 2;
    localparam int Q_DEPTH = 2;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO_DIV = 2'd2;

    // One classified job handed from the front end to the back end.
    typedef struct packed {
        logic [WORD_W-1:0] pn;
        logic [WORD_W-1:0] pd;
        logic [WORD_W-1:0] qn;
        logic [WORD_W-1:0] qd;
        logic              do_prod;
        logic              do_quot;
        logic [ERR_W-1:0]  err;
    } t_job;

endpackage

// ===== hdl/fmdr_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle, on 32-bit words.
module fmdr_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_dividend,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [fmdr_pkg::WORD_W-1:0]   o_quot,
    output logic [fmdr_pkg::WORD_W-1:0]   o_rem
);
    localparam int W = fmdr_pkg::WORD_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    n_trial;

    assign n_trial = {r_rem, r_q[W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (n_trial[W]) begin
                    r_rem <= {r_rem[W-2:0], r_q[W-1]};
                    r_q   <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_rem <= n_trial[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ===== hdl/fmdr_front.sv =====
// Front end: sign-extends the numerators and zero-extends the denominators,
// forms the cross products and the error code, and pushes a job into a short queue.
module fmdr_front #(
    parameter int NUM_WIDTH = fmdr_pkg::NUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [fmdr_pkg::IN_W-1:0]   i_first_num,
    input  logic [fmdr_pkg::IN_W-1:0]   i_first_den,
    input  logic [fmdr_pkg::IN_W-1:0]   i_second_num,
    input  logic [fmdr_pkg::IN_W-1:0]   i_second_den,
    input  logic                        i_pop,
    output logic                        o_job_valid,
    output fmdr_pkg::t_job              o_job
);
    localparam int W = fmdr_pkg::WORD_W;
    localparam int D = fmdr_pkg::Q_DEPTH;
    localparam int AW = $clog2(D);
    localparam logic [W-1:0] NUM_MASK = W'((64'd1 << NUM_WIDTH) - 64'd1);

    // Stage register: extended operands (numerators sign-, denominators zero-extended).
    logic [W-1:0] r_n1, r_d1, r_n2, r_d2;
    logic         r_stg;
    logic [AW:0]  r_count;
    logic [AW-1:0] r_wp, r_rp;
    fmdr_pkg::t_job r_mem [D];
    fmdr_pkg::t_job n_job;
    logic          push;

    // Operands keep their low NUM_WIDTH bits; numerators sign-extend from there.
    function automatic logic [W-1:0] sext(input logic [fmdr_pkg::IN_W-1:0] v);
        logic [W-1:0] x;
        x = W'(v) & NUM_MASK;
        return x[NUM_WIDTH-1] ? (x | ~NUM_MASK) : x;
    endfunction

    function automatic logic [W-1:0] zext(input logic [fmdr_pkg::IN_W-1:0] v);
        return W'(v) & NUM_MASK;
    endfunction

    // Accept only while the stage is empty and the queue can take one more.
    assign o_busy = r_stg || (r_count >= (AW+1)'(D - 1) && !i_pop) ||
                    (r_count == (AW+1)'(D));
    assign push = r_stg;

    always_comb begin
        n_job.pn = r_n1 * r_n2;
        n_job.pd = r_d1 * r_d2;
        n_job.qn = r_n1 * r_d2;
        n_job.qd = r_n2 * r_d1;
        if (r_d1 == '0 || r_d2 == '0) begin
            n_job.err = fmdr_pkg::ERR_ZERO_DEN;
            n_job.do_prod = 1'b0;
            n_job.do_quot = 1'b0;
        end else if (r_n2 == '0) begin
            n_job.err = fmdr_pkg::ERR_ZERO_DIV;
            n_job.do_prod = 1'b1;
            n_job.do_quot = 1'b0;
        end else begin
            n_job.err = fmdr_pkg::ERR_OK;
            n_job.do_prod = 1'b1;
            n_job.do_quot = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_n1 <= sext(i_first_num);
            r_d1 <= zext(i_first_den);
            r_n2 <= sext(i_second_num);
            r_d2 <= zext(i_second_den);
        end
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg   <= 1'b0;
            r_count <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
        end else begin
            r_stg <= i_start && !o_busy;
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_count <= r_count + (AW+1)'(push) - (AW+1)'(i_pop);
        end
    end

    assign o_job_valid = (r_count != '0);
    assign o_job = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(D)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("queue underflow");
    a_stage_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> push) else $error("stage not pushed");
endmodule

// ===== hdl/fmdr_back.sv =====
// Back end: reduces each requested pair by Euclid's gcd on a shared serial divider.
module fmdr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  fmdr_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [fmdr_pkg::WORD_W-1:0]   o_prod_num,
    output logic [fmdr_pkg::WORD_W-1:0]   o_prod_den,
    output logic [fmdr_pkg::WORD_W-1:0]   o_quot_num,
    output logic [fmdr_pkg::WORD_W-1:0]   o_quot_den,
    output logic [fmdr_pkg::ERR_W-1:0]    o_error_code
);
    localparam int W = fmdr_pkg::WORD_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_GCD   = 7'b0000100,
        S_DIVA  = 7'b0001000,
        S_DIVB  = 7'b0010000,
        S_FIX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    fmdr_pkg::t_job r_job;
    logic          r_sel;      // 0 product pair, 1 quotient pair
    logic          r_wait;
    logic [W-1:0]  r_a, r_b, r_n, r_g;
    logic [W-1:0]  r_pn, r_pd, r_qn, r_qd;
    logic          r_valid;

    logic          div_start, div_done;
    logic [W-1:0]  div_x, div_y, div_q, div_r;
    logic [W-1:0]  r_x, r_y;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    assign div_x = mag(r_x);
    assign div_y = mag(r_y);

    fmdr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_x),
        .i_divisor  (div_y),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    logic [W-1:0] srem, squo;
    assign srem = r_x[W-1] ? -div_r : div_r;
    assign squo = (r_x[W-1] ^ r_y[W-1]) ? -div_q : div_q;
    assign div_start = r_wait;
    assign o_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_pn  <= '0; r_pd <= '0; r_qn <= '0; r_qd <= '0;
                        r_sel <= 1'b0;
                        r_state <= i_job.do_prod ? S_LOAD : S_OUT;
                    end
                end
                S_LOAD: begin
                    r_a <= r_sel ? r_job.qn : r_job.pn;
                    r_b <= r_sel ? r_job.qd : r_job.pd;
                    r_x <= r_sel ? r_job.qn : r_job.pn;
                    r_y <= r_sel ? r_job.qd : r_job.pd;
                    r_n <= r_sel ? r_job.qd : r_job.pd;
                    r_wait  <= 1'b1;
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (div_done) begin
                        if (srem == '0) begin
                            r_g <= r_n;
                            if (r_a == '0) begin
                                r_state <= S_FIX;
                            end else begin
                                r_x <= r_a; r_y <= r_n;
                                r_wait <= 1'b1;
                                r_state <= S_DIVA;
                            end
                        end else begin
                            r_n <= srem;
                            r_x <= r_n; r_y <= srem;
                            r_wait <= 1'b1;
                        end
                    end
                end
                S_DIVA: begin
                    if (div_done) begin
                        r_a <= squo;
                        r_x <= r_b; r_y <= r_g;
                        r_wait <= 1'b1;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (div_done) begin
                        r_b <= squo;
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_a != '0 && r_b[W-1]) begin
                        if (r_sel) begin r_qn <= -r_a; r_qd <= -r_b; end
                        else begin r_pn <= -r_a; r_pd <= -r_b; end
                    end else begin
                        if (r_sel) begin r_qn <= r_a; r_qd <= r_b; end
                        else begin r_pn <= r_a; r_pd <= r_b; end
                    end
                    if (!r_sel && r_job.do_quot) begin
                        r_sel <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_prod_num   = r_pn;
    assign o_prod_den   = r_pd;
    assign o_quot_num   = r_qn;
    assign o_quot_den   = r_qd;
    assign o_error_code = r_job.err;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != S_IDLE) else $error("pop without start");
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> o_valid) else $error("result strobe missing");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_y != '0) else $error("divide by zero");
endmodule

// ===== hdl/fraction_multiply_divide_reduce_unit.sv =====
// Fraction multiply/divide with gcd reduction.
//
// Command channel: drive i_first_num, i_first_den, i_second_num and
// i_second_den and raise start; the transaction is taken at the edge where
// start is high and busy is low. Each result appears on the o_ ports for
// exactly one cycle with o_valid high; the receiver cannot stall, so a result
// is never held back waiting for it.
//
// The front end registers and classifies the operands and forms the four
// cross products, then pushes a job into a two-entry queue. The back end
// reduces the product pair and then, if the second numerator is nonzero, the
// quotient pair by Euclid's algorithm, running every remainder and final
// division on one shared bit-serial divider; a pair runs one division per
// remainder step plus, with a nonzero numerator, two final divisions. Items
// with a zero denominator skip both reductions and go straight to the result
// strobe.
//
// Reset is synchronous and active low; it empties the queue and returns the
// back end to idle. No clearing pass is needed.
module fraction_multiply_divide_reduce_unit #(
    parameter int NUM_WIDTH = fmdr_pkg::NUM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fmdr_pkg::IN_W-1:0]     i_first_num,
    input  logic [fmdr_pkg::IN_W-1:0]     i_first_den,
    input  logic [fmdr_pkg::IN_W-1:0]     i_second_num,
    input  logic [fmdr_pkg::IN_W-1:0]     i_second_den,
    output logic                          o_valid,
    output logic [fmdr_pkg::WORD_W-1:0]   o_prod_num,
    output logic [fmdr_pkg::WORD_W-1:0]   o_prod_den,
    output logic [fmdr_pkg::WORD_W-1:0]   o_quot_num,
    output logic [fmdr_pkg::WORD_W-1:0]   o_quot_den,
    output logic [fmdr_pkg::ERR_W-1:0]    o_error_code
);
    logic           pop, job_valid;
    fmdr_pkg::t_job job;

    // Front end: operand capture, classification and the job queue.
    fmdr_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_first_num  (i_first_num),
        .i_first_den  (i_first_den),
        .i_second_num (i_second_num),
        .i_second_den (i_second_den),
        .i_pop        (pop),
        .o_job_valid  (job_valid),
        .o_job        (job)
    );

    // Back end: the two reductions and the result strobe.
    fmdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_prod_num   (o_prod_num),
        .o_prod_den   (o_prod_den),
        .o_quot_num   (o_quot_num),
        .o_quot_den   (o_quot_den),
        .o_error_code (o_error_code)
    );
endmodule

// ===== tb/fmdr_checker.sv =====
`timescale 1ns / 100ps

module fmdr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [fmdr_pkg::IN_W-1:0]     i_first_num,
    input  logic [fmdr_pkg::IN_W-1:0]     i_first_den,
    input  logic [fmdr_pkg::IN_W-1:0]     i_second_num,
    input  logic [fmdr_pkg::IN_W-1:0]     i_second_den,
    input  logic                          i_valid,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_prod_num,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_prod_den,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_quot_num,
    input  logic [fmdr_pkg::WORD_W-1:0]   i_quot_den,
    input  logic [fmdr_pkg::ERR_W-1:0]    i_error_code,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct {
        logic [fmdr_pkg::WORD_W-1:0] pn;
        logic [fmdr_pkg::WORD_W-1:0] pd;
        logic [fmdr_pkg::WORD_W-1:0] qn;
        logic [fmdr_pkg::WORD_W-1:0] qd;
        logic [fmdr_pkg::ERR_W-1:0]  err;
    } t_fraction_result;

    t_fraction_result expected_fracs[$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_fracs.size();

    function automatic logic [31:0] magnitude(logic [31:0] x);
        return x[31] ? 32'd0 - x : x;
    endfunction

    // Remainder and quotient truncate toward zero, and wrap on overflow.
    function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        r = magnitude(a) % magnitude(b);
        return a[31] ? 32'd0 - r : r;
    endfunction

    function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        q = magnitude(a) / magnitude(b);
        return (a[31] ^ b[31]) ? 32'd0 - q : q;
    endfunction

    function automatic void reduce_pair(inout logic [31:0] a, inout logic [31:0] b);
        logic [31:0] m, n, r;
        m = a;
        n = b;
        r = trunc_rem(m, n);
        while (r != 0) begin
            m = n;
            n = r;
            r = trunc_rem(m, n);
        end
        if (a != 0) begin
            a = trunc_div(a, n);
            b = trunc_div(b, n);
        end
        if (a != 0 && b[31]) begin
            a = 32'd0 - a;
            b = 32'd0 - b;
        end
    endfunction

    function automatic t_fraction_result predict_fraction(logic [15:0] n1_in, logic [15:0] d1_in,
                                                          logic [15:0] n2_in, logic [15:0] d2_in);
        t_fraction_result res;
        logic [31:0] n1, d1, n2, d2;
        n1 = {{16{n1_in[15]}}, n1_in};
        n2 = {{16{n2_in[15]}}, n2_in};
        d1 = {16'd0, d1_in};
        d2 = {16'd0, d2_in};
        res = '{pn: '0, pd: '0, qn: '0, qd: '0, err: fmdr_pkg::ERR_OK};
        if (d1 == 0 || d2 == 0) begin
            res.err = fmdr_pkg::ERR_ZERO_DEN;
        end else begin
            res.pn = n1 * n2;
            res.pd = d1 * d2;
            reduce_pair(res.pn, res.pd);
            if (n2 == 0) begin
                res.err = fmdr_pkg::ERR_ZERO_DIV;
            end else begin
                res.qn = n1 * d2;
                res.qd = n2 * d1;
                reduce_pair(res.qn, res.qd);
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fraction_result exp_r;
        if (i_rst_n) begin
            if (i_valid) begin
                if (expected_fracs.size() == 0) begin
                    $display("%0t: result with no transaction pending, actual %h %h %h %h %h",
                             $time, i_prod_num, i_prod_den, i_quot_num, i_quot_den,
                             i_error_code);
                    fail_count++;
                end else begin
                    exp_r = expected_fracs.pop_front();
                    check_field("prod_num", exp_r.pn, i_prod_num);
                    check_field("prod_den", exp_r.pd, i_prod_den);
                    check_field("quot_num", exp_r.qn, i_quot_num);
                    check_field("quot_den", exp_r.qd, i_quot_den);
                    check_field("error_code", 32'(exp_r.err), 32'(i_error_code));
                end
            end
            if (i_start && !i_busy)
                expected_fracs.push_back(predict_fraction(i_first_num, i_first_den,
                                                          i_second_num, i_second_den));
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // An idle stretch that reaches WATCHDOG_LIMIT, with no transaction in either
    // direction, means the block has hung.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int CALM_ITEMS     = 200;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [fmdr_pkg::IN_W-1:0]     first_num = '0;
    logic [fmdr_pkg::IN_W-1:0]     first_den = '0;
    logic [fmdr_pkg::IN_W-1:0]     second_num = '0;
    logic [fmdr_pkg::IN_W-1:0]     second_den = '0;
    logic                          o_valid;
    logic [fmdr_pkg::WORD_W-1:0]   prod_num, prod_den, quot_num, quot_den;
    logic [fmdr_pkg::ERR_W-1:0]    error_code;
    int                            fail_count;
    int                            pending;
    int                            idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fraction_multiply_divide_reduce_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_first_num  (first_num),
        .i_first_den  (first_den),
        .i_second_num (second_num),
        .i_second_den (second_den),
        .o_valid      (o_valid),
        .o_prod_num   (prod_num),
        .o_prod_den   (prod_den),
        .o_quot_num   (quot_num),
        .o_quot_den   (quot_den),
        .o_error_code (error_code)
    );

    fmdr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_first_num  (first_num),
        .i_first_den  (first_den),
        .i_second_num (second_num),
        .i_second_den (second_den),
        .i_valid      (o_valid),
        .i_prod_num   (prod_num),
        .i_prod_den   (prod_den),
        .i_quot_num   (quot_num),
        .i_quot_den   (quot_den),
        .i_error_code (error_code),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The watchdog restarts whenever a command is taken or a result appears.
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("fraction_multiply_divide_reduce_unit test failed");
                $finish;
            end
        end
    end

    // Presents one transaction and returns at the edge where it is taken.
    // The caller either presents the next one at that same edge or lowers start.
    task automatic issue_fraction_pair(logic [15:0] n1, logic [15:0] d1,
                                       logic [15:0] n2, logic [15:0] d2);
        first_num  <= n1;
        first_den  <= d1;
        second_num <= n2;
        second_den <= d2;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    // Random values lean toward small magnitudes and shared factors, so the
    // reductions actually divide something, with full-range and zero values mixed in.
    function automatic logic [15:0] pick_value(bit allow_zero);
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = 16'($urandom_range(1, 12) * $urandom_range(1, 60));
            3:       v = 16'($urandom_range(0, 15)) | 16'h8000;
            4:       v = 16'hFFFF - 16'($urandom_range(0, 7));
            5:       v = allow_zero ? 16'd0 : 16'd1;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        logic [15:0] n1, d1, n2, d2;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each error case, both faults at once,
        // wrapped products and the most negative value over minus one.
        issue_fraction_pair(16'd1, 16'd2, 16'd3, 16'd4);
        issue_fraction_pair(16'd6, 16'd8, 16'd9, 16'd12);
        issue_fraction_pair(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        issue_fraction_pair(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF);
        issue_fraction_pair(16'h8000, 16'd1, 16'hFFFF, 16'd1);
        issue_fraction_pair(16'h8000, 16'hFFFF, 16'hFFFF, 16'd1);
        issue_fraction_pair(16'hFFFF, 16'd1, 16'h8000, 16'hFFFF);
        issue_fraction_pair(16'd5, 16'd0, 16'd3, 16'd7);
        issue_fraction_pair(16'd5, 16'd3, 16'd3, 16'd0);
        issue_fraction_pair(16'd5, 16'd0, 16'd0, 16'd0);
        issue_fraction_pair(16'd7, 16'd3, 16'd0, 16'd9);
        issue_fraction_pair(16'd0, 16'd5, 16'd0, 16'd5);
        issue_fraction_pair(16'd0, 16'd5, 16'd4, 16'd6);
        issue_fraction_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8001);
        issue_fraction_pair(16'h7FFF, 16'h8000, 16'hFFF0, 16'h8000);
        issue_fraction_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        issue_fraction_pair(16'hFFFE, 16'd1, 16'h0002, 16'd1);
        issue_fraction_pair(16'd1, 16'd1, 16'd1, 16'd1);

        // Hold off until every outstanding result has come back.
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            n1 = pick_value(1'b1);
            n2 = pick_value($urandom_range(0, 9) == 0);
            d1 = pick_value($urandom_range(0, 19) == 0);
            d2 = pick_value($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 4) == 0) begin
                // Reuse the numerators as the denominators so the product pair shares factors.
                d2 = n1;
                d1 = n2;
            end
            issue_fraction_pair(n1, d1, n2, d2);
            if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                idle_burst();
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("fraction_multiply_divide_reduce_unit test passed");
        else
            $display("fraction_multiply_divide_reduce_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fmdr_pkg.sv
hdl/fmdr_divider.sv
hdl/fmdr_front.sv
hdl/fmdr_back.sv
hdl/fraction_multiply_divide_reduce_unit.sv
tb/fmdr_checker.sv
tb/tb.sv
